// File: src/mbhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbhp_pkg;

    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

    localparam logic [1:0] KIND_BOX   = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_EXT_TRUNC = 2'd1;
    localparam logic [1:0] ERR_TOO_SMALL = 2'd2;
    localparam logic [1:0] ERR_OVERRUN   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_EXT,
        PH_SKIP,
        PH_TAIL,
        PH_ERR
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] box_name;
        logic        long_header;
        logic [47:0] payload_offset;
        logic [47:0] payload_size;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic    rec_valid;
        logic    fin_valid;
        result_t rec;
        result_t fin;
    } push_t;

endpackage

`default_nettype wire

// File: src/mp4_box_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    data_byte, start_req
// m_        out        m_valid/m_ready    kind, box_name, long_header, payload_offset,
//                                         payload_size, error_code, last
// cfg_      in         cfg_valid/cfg_ready buffer length (cfg_data)
//
// One byte per cycle while s_ready is high: a byte is held in the input register, then
// the parse stage pushes zero, one or two results into an 8-entry result queue.
// The first result of a byte passes the input register and the result queue before m_ shows it.
// s_ready drops only while the queue cannot take two more results behind the byte in flight.
// Synchronous active-low reset clears parser state, queue pointers and sets the length to 1.

module mp4_box_header_parser #(
    parameter int LENGTH_BITS = 48
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_start_req,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_box_name,
    output logic        m_long_header,
    output logic [47:0] m_payload_offset,
    output logic [47:0] m_payload_size,
    output logic [1:0]  m_error_code,
    output logic        m_last,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [47:0] cfg_data
);
    import mbhp_pkg::*;

    localparam int CW = OUT_PTR_W + 2;

    logic [LENGTH_BITS-1:0] buf_len_reg, buf_len_next;
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    push_t                  push;
    result_t                out_data;
    logic [OUT_PTR_W:0]     count;
    logic [CW-1:0]          fill;

    assign cfg_ready = 1'b1;
    assign fill      = CW'(count) + (in_valid_reg ? CW'(2) : CW'(0));
    assign s_ready   = (fill <= CW'(OUT_DEPTH - 2));

    always_comb begin
        buf_len_next  = (cfg_valid && cfg_ready) ? LENGTH_BITS'(cfg_data) : buf_len_reg;
        in_valid_next = s_valid & s_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg  <= LENGTH_BITS'(1);
            in_valid_reg <= 1'b0;
        end else begin
            buf_len_reg  <= buf_len_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_start_reg <= s_start_req;
        end
    end

    mbhp_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_start (in_start_reg),
        .buf_len  (buf_len_reg),
        .push     (push)
    );

    mbhp_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data),
        .count     (count)
    );

    assign m_kind           = out_data.kind;
    assign m_box_name       = out_data.box_name;
    assign m_long_header    = out_data.long_header;
    assign m_payload_offset = out_data.payload_offset;
    assign m_payload_size   = out_data.payload_size;
    assign m_error_code     = out_data.error_code;
    assign m_last           = out_data.last;

endmodule

`default_nettype wire

// File: src/mbhp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mbhp_core #(
    parameter int LENGTH_BITS = 48
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    input  wire [7:0]             in_byte,
    input  wire                   in_start,
    input  wire [LENGTH_BITS-1:0] buf_len,
    output mbhp_pkg::push_t       push
);
    import mbhp_pkg::*;

    localparam int LB = LENGTH_BITS;

    phase_t        phase_reg, phase_next;
    logic [3:0]    hbs_reg, hbs_next;
    logic [31:0]   short_reg, short_next;
    logic [31:0]   name_reg, name_next;
    logic [63:0]   long_reg, long_next;
    logic [LB-1:0] skip_reg, skip_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [1:0]    err_reg, err_next;

    phase_t        ph;
    logic [3:0]    hbs;
    logic [31:0]   sh;
    logic [31:0]   nm;
    logic [63:0]   ls;
    logic [LB-1:0] skip;
    logic [LB-1:0] pos;
    logic [1:0]    err;
    logic [LB-1:0] rem;
    logic          hdr_done;
    logic          emit;
    logic          emit_lh;
    logic [63:0]   emit_pl;
    logic          rec_v;
    logic          fin_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hbs_reg   <= '0;
            short_reg <= '0;
            name_reg  <= '0;
            long_reg  <= '0;
            skip_reg  <= '0;
            pos_reg   <= '0;
            err_reg   <= ERR_NONE;
        end else begin
            phase_reg <= phase_next;
            hbs_reg   <= hbs_next;
            short_reg <= short_next;
            name_reg  <= name_next;
            long_reg  <= long_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    always_comb begin
        ph       = phase_reg;
        hbs      = hbs_reg;
        sh       = short_reg;
        nm       = name_reg;
        ls       = long_reg;
        skip     = skip_reg;
        pos      = pos_reg;
        err      = err_reg;
        rem      = '0;
        hdr_done = 1'b0;
        emit     = 1'b0;
        emit_lh  = 1'b0;
        emit_pl  = '0;
        rec_v    = 1'b0;
        fin_v    = 1'b0;
        push     = '0;

        if (in_valid) begin
            if (in_start) begin
                ph   = PH_HDR;
                hbs  = '0;
                pos  = '0;
                err  = ERR_NONE;
                skip = '0;
            end
            if (ph != PH_IDLE) begin
                if (pos >= buf_len) begin
                    ph = PH_IDLE;
                end else begin
                    rem = buf_len - LB'(1) - pos;
                    case (ph)
                        PH_HDR: begin
                            if (hbs == 4'd0 && rem < LB'(7)) begin
                                ph = PH_TAIL;
                            end else begin
                                if (hbs == 4'd0) begin
                                    sh = '0;
                                    nm = '0;
                                end
                                if (hbs < 4'd4) begin
                                    sh = {sh[23:0], in_byte};
                                end else begin
                                    case (hbs[1:0])
                                        2'd0:    nm[7:0]   = in_byte;
                                        2'd1:    nm[15:8]  = in_byte;
                                        2'd2:    nm[23:16] = in_byte;
                                        default: nm[31:24] = in_byte;
                                    endcase
                                end
                                hdr_done = (hbs == 4'd7);
                                hbs      = hbs + 4'd1;
                                if (hdr_done) begin
                                    if (sh == 32'd1) begin
                                        if (rem < LB'(8)) begin
                                            err = ERR_EXT_TRUNC;
                                            ph  = PH_ERR;
                                        end else begin
                                            ls = '0;
                                            ph = PH_EXT;
                                        end
                                    end else if (sh == 32'd0) begin
                                        emit    = 1'b1;
                                        emit_pl = 64'(rem);
                                    end else if (sh < 32'd8) begin
                                        err = ERR_TOO_SMALL;
                                        ph  = PH_ERR;
                                    end else if (64'(sh - 32'd8) > 64'(rem)) begin
                                        err = ERR_OVERRUN;
                                        ph  = PH_ERR;
                                    end else begin
                                        emit    = 1'b1;
                                        emit_pl = 64'(sh - 32'd8);
                                    end
                                end
                            end
                        end
                        PH_EXT: begin
                            ls       = {ls[55:0], in_byte};
                            hdr_done = (hbs == 4'd15);
                            hbs      = hbs + 4'd1;
                            if (hdr_done) begin
                                if (ls < 64'd16) begin
                                    err = ERR_TOO_SMALL;
                                    ph  = PH_ERR;
                                end else if (ls - 64'd16 > 64'(rem)) begin
                                    err = ERR_OVERRUN;
                                    ph  = PH_ERR;
                                end else begin
                                    emit    = 1'b1;
                                    emit_lh = 1'b1;
                                    emit_pl = ls - 64'd16;
                                end
                            end
                        end
                        PH_SKIP: begin
                            if (skip != '0) begin
                                skip = skip - LB'(1);
                            end
                            if (skip == '0) begin
                                hbs = '0;
                                ph  = PH_HDR;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (emit) begin
                        rec_v                    = 1'b1;
                        push.rec.kind            = KIND_BOX;
                        push.rec.box_name        = nm;
                        push.rec.long_header     = emit_lh;
                        push.rec.payload_offset  = 48'(pos + LB'(1));
                        push.rec.payload_size    = 48'(emit_pl);
                        push.rec.error_code      = ERR_NONE;
                        skip                     = LB'(emit_pl);
                        hbs                      = '0;
                        ph                       = (skip != '0) ? PH_SKIP : PH_HDR;
                    end

                    if (rem == '0) begin
                        fin_v = 1'b1;
                        if (err != ERR_NONE) begin
                            push.fin.kind       = KIND_ERROR;
                            push.fin.error_code = err;
                        end else begin
                            push.fin.kind       = KIND_DONE;
                            push.fin.error_code = ERR_NONE;
                        end
                        ph = PH_IDLE;
                    end
                    pos = pos + LB'(1);
                end
            end
        end

        push.rec_valid = rec_v;
        push.fin_valid = fin_v;
        push.rec.last  = rec_v & ~fin_v;
        push.fin.last  = fin_v;

        phase_next = ph;
        hbs_next   = hbs;
        short_next = sh;
        name_next  = nm;
        long_next  = ls;
        skip_next  = skip;
        pos_next   = pos;
        err_next   = err;
    end

endmodule

`default_nettype wire

// File: src/mbhp_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mbhp_out_queue (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  mbhp_pkg::push_t              push,
    output logic                         out_valid,
    input  wire                          out_ready,
    output mbhp_pkg::result_t            out_data,
    output logic [mbhp_pkg::OUT_PTR_W:0] count
);
    import mbhp_pkg::*;

    result_t              q_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_PTR_W:0]   count_reg, count_next;
    logic [OUT_PTR_W:0]   n_push;
    logic                 pop;
    result_t              first;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid & out_ready;
    assign first     = push.rec_valid ? push.rec : push.fin;
    assign n_push    = (OUT_PTR_W+1)'(push.rec_valid) + (OUT_PTR_W+1)'(push.fin_valid);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + OUT_PTR_W'(pop);
        count_next  = count_reg + n_push - (OUT_PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.rec_valid || push.fin_valid) begin
            q_reg[wr_ptr_reg] <= first;
        end
        if (push.rec_valid && push.fin_valid) begin
            q_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= push.fin;
        end
    end

endmodule

`default_nettype wire
